>>> src/ptu_pkg.sv
package ptu_pkg;

  localparam int MAC_W    = 48;
  localparam int RSSI_W   = 8;
  localparam int HASH_W   = 32;
  localparam int BIT_W    = 6;
  localparam int DIST_W   = 24;
  localparam int TIME_W   = 32;
  localparam int HITS_W   = 16;
  localparam int MAP_W    = 64;
  localparam int GEN_W    = 32;
  localparam int SLOT_W   = 4;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 144;

  localparam logic [HITS_W-1:0] HIT_MAX    = 16'hFFFF;
  localparam logic [RSSI_W-1:0] RSSI_RESET = 8'h9C;
  localparam logic [7:0]        NEW_WEIGHT = 8'd51;
  localparam logic [7:0]        OLD_WEIGHT = 8'd205;

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] seen_ms;
    logic [TIME_W-1:0] join_ms;
    logic [HITS_W-1:0] hits;
    logic [MAP_W-1:0]  bitmap;
    logic [RSSI_W-1:0] rssi;
    logic [HASH_W-1:0] hw_hash;
    logic [DIST_W-1:0] dist_avg;
    logic [GEN_W-1:0]  gen;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    mac:        '0,
    seen_ms:    '0,
    join_ms:    '0,
    hits:       '0,
    bitmap:     '0,
    rssi:       RSSI_RESET,
    hw_hash:    '0,
    dist_avg:   '0,
    gen:        '0
  };

  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [RSSI_W-1:0] rssi;
    logic [HASH_W-1:0] hw_hash;
    logic [BIT_W-1:0]  ssid_bit;
    logic              ssid_valid;
    logic [DIST_W-1:0] raw_distance;
    logic [TIME_W-1:0] time_ms;
  } probe_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              new_device;
    logic [HITS_W-1:0] hit_count;
    logic [MAP_W-1:0]  ssid_bitmap;
    logic [DIST_W-1:0] avg_distance;
    logic [GEN_W-1:0]  slot_generation;
  } result_t;

endpackage

>>> src/probe_table_update_lru.sv
// Channel  Direction  Payload
// s_*      in         one probe request (mac, rssi, hw_hash, ssid_bit, raw_distance, time_ms)
// m_*      out        one result per request (slot, hit_count, bitmap, distance, generation)
//
// Requests are handled one at a time: the scan reads one slot per cycle
// through the single read port of the slot memory, and the next request is
// accepted only after the previous result has been written back.
// Reset clears the per-slot written flags at once; unwritten slots read as empty.
// A result waits in the output register while the next request is scanned;
// the write-back stalls only while that register is full and m_tready is low.
module probe_table_update_lru #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // mac, rssi, hw_hash, ssid_bit, raw_distance, time_ms, zero pad
  input  logic [ptu_pkg::IN_DATA_W-1:0]   s_tdata,
  // ssid_valid
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // slot, hit_count, ssid_bitmap, avg_distance, slot_generation, zero pad
  output logic [ptu_pkg::OUT_DATA_W-1:0]  m_tdata,
  // new_device
  output logic                            m_tuser
);
  import ptu_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);

  probe_t        probe;
  result_t       res;
  result_t       out_q;
  logic          res_valid;
  logic          res_ready;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  assign probe.mac          = s_tdata[47:0];
  assign probe.rssi         = s_tdata[55:48];
  assign probe.hw_hash      = s_tdata[87:56];
  assign probe.ssid_bit     = s_tdata[93:88];
  assign probe.raw_distance = s_tdata[117:94];
  assign probe.time_ms      = s_tdata[149:118];
  assign probe.ssid_valid   = s_tuser;

  ptu_mem #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ptu_engine #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_probe  (probe),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tdata = {4'd0, out_q.slot_generation, out_q.avg_distance,
                    out_q.ssid_bitmap, out_q.hit_count, out_q.slot};
  assign m_tuser = out_q.new_device;

endmodule

>>> src/ptu_mem.sv
module ptu_mem #(
  parameter int SLOT_COUNT = 16,
  parameter int IW = $clog2(SLOT_COUNT)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output ptu_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  ptu_pkg::entry_t wr_data
);
  import ptu_pkg::*;

  entry_t                mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] written;
  entry_t                rd_q;
  logic                  rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_written ? rd_q : ENTRY_RESET;

endmodule

>>> src/ptu_engine.sv
module ptu_engine #(
  parameter int SLOT_COUNT = 16,
  parameter int IW = $clog2(SLOT_COUNT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ptu_pkg::probe_t  in_probe,
  output logic             res_valid,
  input  logic             res_ready,
  output ptu_pkg::result_t res,
  output logic             rd_en,
  output logic [IW-1:0]    rd_addr,
  input  ptu_pkg::entry_t  rd_data,
  output logic             wr_en,
  output logic [IW-1:0]    wr_addr,
  output ptu_pkg::entry_t  wr_data
);
  import ptu_pkg::*;

  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_MIX   = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t        state;
  probe_t        req;
  logic [CW-1:0] idx;
  logic          chk_valid;
  logic [IW-1:0] chk_idx;
  logic          found;
  logic [IW-1:0] tgt_idx;
  entry_t        tgt_ent;
  logic [IW-1:0] old_idx;
  entry_t        old_ent;
  entry_t        upd_ent;
  logic [IW-1:0] upd_idx;
  logic          upd_new;

  entry_t        base;
  entry_t        upd_next;
  logic [32:0]   acc;

  assign in_ready  = (state == S_IDLE);
  assign rd_en     = (state == S_SCAN) && (idx < CW'(SLOT_COUNT));
  assign rd_addr   = idx[IW-1:0];
  assign res_valid = (state == S_WRITE);
  assign wr_en     = (state == S_WRITE) && res_ready;
  assign wr_addr   = upd_idx;
  assign wr_data   = upd_ent;

  always_comb begin
    if (found) begin
      base = tgt_ent;
    end else begin
      base            = old_ent;
      base.mac        = req.mac;
      base.hits       = '0;
      base.bitmap     = '0;
      base.join_ms    = req.time_ms;
      base.gen        = old_ent.gen + GEN_W'(1);
    end
    upd_next           = base;
    upd_next.hits      = (base.hits != HIT_MAX) ? base.hits + HITS_W'(1) : base.hits;
    upd_next.seen_ms   = req.time_ms;
    upd_next.rssi      = req.rssi;
    upd_next.hw_hash   = req.hw_hash;
    acc = 33'(req.raw_distance) * 33'(NEW_WEIGHT) + 33'(base.dist_avg) * 33'(OLD_WEIGHT);
    if (req.raw_distance != '0) begin
      if (upd_next.hits == HITS_W'(1)) begin
        upd_next.dist_avg = req.raw_distance;
      end else begin
        upd_next.dist_avg = acc[DIST_W+7:8];
      end
    end
    if (req.ssid_valid) begin
      upd_next.bitmap = base.bitmap | (MAP_W'(1) << req.ssid_bit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            idx       <= '0;
            chk_valid <= 1'b0;
            found     <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            idx <= idx + CW'(1);
          end
          chk_valid <= rd_en;
          if (chk_valid) begin
            if (!found && rd_data.mac == req.mac) begin
              found <= 1'b1;
            end
            if (chk_idx == IW'(SLOT_COUNT - 1)) begin
              state <= S_MIX;
            end
          end
        end
        S_MIX: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      req <= in_probe;
    end
    if (state == S_SCAN) begin
      chk_idx <= idx[IW-1:0];
      if (chk_valid) begin
        if (!found && rd_data.mac == req.mac) begin
          tgt_idx <= chk_idx;
          tgt_ent <= rd_data;
        end
        if (chk_idx == '0 || rd_data.seen_ms < old_ent.seen_ms) begin
          old_idx <= chk_idx;
          old_ent <= rd_data;
        end
      end
    end
    if (state == S_MIX) begin
      upd_ent <= upd_next;
      upd_idx <= found ? tgt_idx : old_idx;
      upd_new <= !found;
    end
  end

  assign res.slot            = SLOT_W'(upd_idx);
  assign res.new_device      = upd_new;
  assign res.hit_count       = upd_ent.hits;
  assign res.ssid_bitmap     = upd_ent.bitmap;
  assign res.avg_distance    = upd_ent.dist_avg;
  assign res.slot_generation = upd_ent.gen;

endmodule
